### hdl/mtr_pkg.sv
package mtr_pkg;

	localparam int unsigned FrameLen   = 101;
	localparam int unsigned SearchLen  = 5;
	localparam int unsigned SumFirst   = 4;
	localparam int unsigned SumLast    = 98;
	localparam int unsigned SumPos     = 99;
	localparam int unsigned AccessPos  = 15;
	localparam int unsigned PayloadPos = 19;
	localparam int unsigned NumBlocks  = 5;

	typedef logic [6:0] idx_t;
	typedef logic [7:0] byte_t;

	typedef enum logic [1:0] {
		OP_DATA  = 2'd0,
		OP_LERR  = 2'd1,
		OP_POLL  = 2'd2,
		OP_SPARE = 2'd3
	} op_t;

	typedef enum logic [2:0] {
		ST_NONE    = 3'd0,
		ST_MATCH   = 3'd1,
		ST_GOOD    = 3'd2,
		ST_BADSUM  = 3'd3,
		ST_TIMEOUT = 3'd4,
		ST_LINEERR = 3'd5
	} status_t;

	typedef enum logic [1:0] {
		REG_KEY_LOW  = 2'd0,
		REG_KEY_HIGH = 2'd1,
		REG_IV_LOW   = 2'd2,
		REG_TIMEOUT  = 2'd3
	} reg_t;

	function automatic byte_t link_reset_byte(input logic [2:0] i);
		byte_t r;
		unique case (i)
			3'd0: r = 8'h10;
			3'd1: r = 8'h40;
			3'd2: r = 8'hf0;
			3'd3: r = 8'h30;
			default: r = 8'h16;
		endcase
		return r;
	endfunction

	function automatic logic [4:0] value_offset(input logic [2:0] k);
		logic [4:0] r;
		unique case (k)
			3'd0: r = 5'd0;
			default: r = 5'd0;
		endcase
		return r;
	endfunction

	function automatic byte_t sbox(input byte_t x);
		logic [0:255][7:0] t;
		t = {
		128'h637c777bf26b6fc53001672bfed7ab76, 128'hca82c97dfa5947f0add4a2af9ca472c0,
		128'hb7fd9326363ff7cc34a5e5f171d83115, 128'h04c723c31896059a071280e2eb27b275,
		128'h09832c1a1b6e5aa0523bd6b329e32f84, 128'h53d100ed20fcb15b6acbbe394a4c58cf,
		128'hd0efaafb434d338545f9027f503c9fa8, 128'h51a3408f929d38f5bcb6da2110fff3d2,
		128'hcd0c13ec5f974417c4a77e3d645d1973, 128'h60814fdc222a908846eeb814de5e0bdb,
		128'he0323a0a4906245cc2d3ac629195e479, 128'he7c8376d8dd54ea96c56f4ea657aae08,
		128'hba78252e1ca6b4c6e8dd741f4bbd8b8a, 128'h703eb5664803f60e613557b986c11d9e,
		128'he1f8981169d98e949b1e87e9ce5528df, 128'h8ca1890dbfe6426841992d0fb054bb16};
		return t[x];
	endfunction

	function automatic byte_t inv_sbox(input byte_t x);
		logic [0:255][7:0] t;
		t = {
		128'h52096ad53036a538bf40a39e81f3d7fb, 128'h7ce339829b2fff87348e4344c4dee9cb,
		128'h547b9432a6c2233dee4c950b42fac34e, 128'h082ea16628d924b2765ba2496d8bd125,
		128'h72f8f66486689816d4a45ccc5d65b692, 128'h6c704850fdedb9da5e154657a78d9d84,
		128'h90d8ab008cbcd30af7e45805b8b34506, 128'hd02c1e8fca3f0f02c1afbd0301138a6b,
		128'h3a9111414f67dcea97f2cfcef0b4e673, 128'h96ac7422e7ad3585e2f937e81c75df6e,
		128'h47f11a711d29c5896fb7620eaa18be1b, 128'hfc563e4bc6d279209adbc0fe78cd5af4,
		128'h1fdda8338807c731b11210592780ec5f, 128'h60517fa919b54a0d2de57a9f93c99cef,
		128'ha0e03b4dae2af5b0c8ebbb3c83539961, 128'h172b047eba77d626e169146355210c7d};
		return t[x];
	endfunction

	function automatic byte_t xt(input byte_t a);
		return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
	endfunction

	// a*9, a*11, a*13, a*14 from doublings
	function automatic logic [31:0] inv_mix_col(input logic [31:0] c);
		byte_t a [4];
		byte_t a2 [4];
		byte_t a4 [4];
		byte_t a8 [4];
		byte_t m9 [4];
		byte_t mb [4];
		byte_t md [4];
		byte_t me [4];
		logic [31:0] r;
		for (int i = 0; i < 4; i++) begin
			a[i]  = c[31-8*i -: 8];
			a2[i] = xt(a[i]);
			a4[i] = xt(a2[i]);
			a8[i] = xt(a4[i]);
			m9[i] = a8[i] ^ a[i];
			mb[i] = a8[i] ^ a2[i] ^ a[i];
			md[i] = a8[i] ^ a4[i] ^ a[i];
			me[i] = a8[i] ^ a4[i] ^ a2[i];
		end
		r[31:24] = me[0] ^ mb[1] ^ md[2] ^ m9[3];
		r[23:16] = m9[0] ^ me[1] ^ mb[2] ^ md[3];
		r[15:8]  = md[0] ^ m9[1] ^ me[2] ^ mb[3];
		r[7:0]   = mb[0] ^ md[1] ^ m9[2] ^ me[3];
		return r;
	endfunction

	// state byte i at [127-8*i -: 8], column-major
	function automatic logic [127:0] inv_shift_sub(input logic [127:0] s);
		logic [127:0] r;
		for (int row = 0; row < 4; row++) begin
			for (int col = 0; col < 4; col++) begin
				r[127-8*(row+4*col) -: 8] = inv_sbox(s[127-8*(row+4*((col-row+4)%4)) -: 8]);
			end
		end
		return r;
	endfunction

	function automatic logic [127:0] inv_mix(input logic [127:0] s);
		logic [127:0] r;
		for (int col = 0; col < 4; col++) begin
			r[127-32*col -: 32] = inv_mix_col(s[127-32*col -: 32]);
		end
		return r;
	endfunction

	// next round key word group, forward direction
	function automatic logic [127:0] key_next(input logic [127:0] k, input byte_t rc);
		logic [31:0] w [4];
		logic [31:0] t;
		logic [127:0] r;
		for (int i = 0; i < 4; i++) w[i] = k[127-32*i -: 32];
		t = {sbox(w[3][23:16]) ^ rc, sbox(w[3][15:8]), sbox(w[3][7:0]), sbox(w[3][31:24])};
		w[0] = w[0] ^ t;
		w[1] = w[1] ^ w[0];
		w[2] = w[2] ^ w[1];
		w[3] = w[3] ^ w[2];
		r = {w[0], w[1], w[2], w[3]};
		return r;
	endfunction

	// inverse key step: previous round key from this one
	function automatic logic [127:0] key_prev(input logic [127:0] k, input byte_t rc);
		logic [31:0] w [4];
		logic [31:0] p [4];
		logic [31:0] t;
		for (int i = 0; i < 4; i++) w[i] = k[127-32*i -: 32];
		p[3] = w[3] ^ w[2];
		p[2] = w[2] ^ w[1];
		p[1] = w[1] ^ w[0];
		t = {sbox(p[3][23:16]) ^ rc, sbox(p[3][15:8]), sbox(p[3][7:0]), sbox(p[3][31:24])};
		p[0] = w[0] ^ t;
		return {p[0], p[1], p[2], p[3]};
	endfunction

	function automatic byte_t rcon(input logic [3:0] i);
		byte_t r;
		unique case (i)
			4'd0: r = 8'h01;
			4'd1: r = 8'h02;
			4'd2: r = 8'h04;
			4'd3: r = 8'h08;
			4'd4: r = 8'h10;
			4'd5: r = 8'h20;
			4'd6: r = 8'h40;
			4'd7: r = 8'h80;
			4'd8: r = 8'h1b;
			default: r = 8'h36;
		endcase
		return r;
	endfunction

endpackage

### hdl/meter_telegram_receiver_core.sv
// Meter telegram receiver core.
// Input channel (in_valid/in_stall): one item per received event, opcode selects
// a data byte, a line error or an idle poll carrying only the millisecond time.
// Output channel (out_valid/out_stall): exactly one result item per input item:
// status plus the eight stored meter values and the three counters.
// Config channel (cfg_valid/cfg_ready/cfg_index/cfg_data): write the key halves,
// the IV low half and the receive timeout while the core is idle.
// Received bytes go into a 128x8 frame memory (one port, registered read).
// Most items pass through S_EMIT to a result. The last byte of a telegram
// starts a sweep: reads of bytes 4..99 for the checksum, then, on a good
// sum, a key schedule run and five blocks each needing 16 byte reads plus
// 10 rounds of the single round unit.
// Throughput: one item at a time; in_stall stays high from acceptance until the
// result has left the output register.
// Reset clears phase, index, counters, meter values and timing; frame memory
// contents are not cleared (every read follows a write).
// A stalled result holds in the output register; the next item is only taken
// once the output register is free.
module meter_telegram_receiver_core #(
	parameter int unsigned TimeoutReset = 2000
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  opcode,
	input  logic [7:0]  rx_byte,
	input  logic [15:0] time_ms,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [63:0] cfg_data,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [2:0]  status,
	output logic [31:0] energy_active_import,
	output logic [31:0] energy_active_export,
	output logic [31:0] energy_reactive_import,
	output logic [31:0] energy_reactive_export,
	output logic [31:0] power_active_import,
	output logic [31:0] power_active_export,
	output logic [31:0] power_reactive_import,
	output logic [31:0] power_reactive_export,
	output logic [7:0]  checksum_error_count,
	output logic [7:0]  line_error_count,
	output logic [7:0]  telegram_count
);

	typedef enum logic [8:0] {
		S_IDLE  = 9'b000000001,
		S_CMP   = 9'b000000010,
		S_SUM   = 9'b000000100,
		S_KEY   = 9'b000001000,
		S_LOAD  = 9'b000010000,
		S_ROUND = 9'b000100000,
		S_XOR   = 9'b001000000,
		S_DONE  = 9'b010000000,
		S_EMIT  = 9'b100000000
	} state_t;

	state_t st_q;

	logic [63:0] key_low_q, key_high_q, iv_low_q;
	logic [15:0] timeout_q;
	logic        phase_q;
	logic [6:0]  idx_q;
	logic [15:0] last_time_q;
	logic [7:0]  sum_err_q, line_err_q, frame_cnt_q;
	logic [31:0] meter_q [8];

	// frame memory, one port
	logic [7:0] mem [128];
	logic       mem_we;
	logic [6:0] mem_addr;
	logic [7:0] mem_wdata;
	logic [7:0] mem_rdata_q;

	always_ff @(posedge clk) begin
		if (mem_we) mem[mem_addr] <= mem_wdata;
		mem_rdata_q <= mem[mem_addr];
	end

	logic [6:0]   rd_q;       // address in flight
	logic         rd_vld_q;   // mem_rdata_q holds data for rd_q issued last cycle
	logic [6:0]   rd_prev_q;
	logic [7:0]   acc_q;      // running checksum
	logic         match_q;
	logic [127:0] rk_q;       // current round key
	logic [127:0] k0_q;       // first round key (user key)
	logic [127:0] st128_q;
	logic [127:0] ct_q;       // ciphertext block, for chaining
	logic [127:0] chain_q;
	logic [3:0]   rnd_q;
	logic [2:0]   blk_q;
	logic [4:0]   cnt_q;
	logic [7:0]   access_q;
	logic [2:0]   status_q;
	logic         out_vld_q;
	logic [15:0]  dt;

	assign dt = time_ms - last_time_q;
	assign in_stall  = (st_q != S_IDLE) || out_vld_q;
	assign cfg_ready = (st_q == S_IDLE);

	logic in_acc;
	assign in_acc = in_valid && !in_stall;

	// memory port mux
	always_comb begin
		mem_we    = 1'b0;
		mem_wdata = rx_byte;
		mem_addr  = rd_q;
		if (in_acc && opcode == mtr_pkg::OP_DATA) begin
			mem_we   = 1'b1;
			mem_addr = (idx_q >= 7'(mtr_pkg::FrameLen)) ? 7'd0 : idx_q;
		end
	end

	logic [127:0] ark, rnd_out;
	assign ark = st128_q ^ rk_q;
	assign rnd_out = mtr_pkg::inv_shift_sub((rnd_q == 4'd10) ? ark : mtr_pkg::inv_mix(ark));

	// plaintext byte i of a 16 byte block, byte 0 in the top bits
	function automatic logic [7:0] pb(input logic [127:0] b, input int i);
		return b[127-8*i -: 8];
	endfunction

	logic [127:0] plain;
	assign plain = st128_q ^ k0_q ^ chain_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= S_IDLE;
			key_low_q   <= '0;
			key_high_q  <= '0;
			iv_low_q    <= 64'h2D4C00000000010E;
			timeout_q   <= 16'(TimeoutReset);
			phase_q     <= 1'b0;
			idx_q       <= '0;
			last_time_q <= '0;
			sum_err_q   <= '0;
			line_err_q  <= '0;
			frame_cnt_q <= '0;
			for (int i = 0; i < 8; i++) meter_q[i] <= '0;
			out_vld_q   <= 1'b0;
			status_q    <= '0;
			rd_q        <= '0;
			rd_vld_q    <= 1'b0;
			rd_prev_q   <= '0;
			acc_q       <= '0;
			match_q     <= 1'b0;
			rk_q        <= '0;
			k0_q        <= '0;
			st128_q     <= '0;
			ct_q        <= '0;
			chain_q     <= '0;
			rnd_q       <= '0;
			blk_q       <= '0;
			cnt_q       <= '0;
			access_q    <= '0;
		end else begin
			if (out_vld_q && !out_stall) out_vld_q <= 1'b0;
			if (cfg_valid && cfg_ready) begin
				unique case (mtr_pkg::reg_t'(cfg_index))
					mtr_pkg::REG_KEY_LOW:  key_low_q  <= cfg_data;
					mtr_pkg::REG_KEY_HIGH: key_high_q <= cfg_data;
					mtr_pkg::REG_IV_LOW:   iv_low_q   <= cfg_data;
					mtr_pkg::REG_TIMEOUT:  timeout_q  <= cfg_data[15:0];
					default: ;
				endcase
			end
			rd_vld_q  <= 1'b0;
			rd_prev_q <= rd_q;
			unique case (st_q)
				S_IDLE: begin
					if (in_acc) begin
						status_q <= mtr_pkg::ST_NONE;
						st_q     <= S_EMIT;
						unique case (mtr_pkg::op_t'(opcode))
							mtr_pkg::OP_DATA: begin
								logic [6:0] ni;
								ni = ((idx_q >= 7'(mtr_pkg::FrameLen)) ? 7'd0 : idx_q) + 7'd1;
								last_time_q <= time_ms;
								idx_q       <= ni;
								if (!phase_q && ni >= 7'(mtr_pkg::SearchLen)) begin
									idx_q   <= '0;
									rd_q    <= '0;
									match_q <= 1'b1;
									st_q    <= S_CMP;
								end else if (phase_q && ni >= 7'(mtr_pkg::FrameLen)) begin
									idx_q <= '0;
									rd_q  <= 7'(mtr_pkg::SumFirst);
									acc_q <= '0;
									st_q  <= S_SUM;
								end
							end
							mtr_pkg::OP_LERR: begin
								if (line_err_q != 8'hff) line_err_q <= line_err_q + 8'd1;
								idx_q <= '0;
								if (dt >= timeout_q) phase_q <= 1'b0;
								status_q <= mtr_pkg::ST_LINEERR;
							end
							mtr_pkg::OP_POLL: begin
								if (dt >= timeout_q) begin
									phase_q  <= 1'b0;
									idx_q    <= '0;
									status_q <= mtr_pkg::ST_TIMEOUT;
								end
							end
							default: ;
						endcase
					end
				end
				// compare the search window; address 5 reads are harmless
				S_CMP: begin
					rd_vld_q <= 1'b1;
					rd_q     <= rd_q + 7'd1;
					if (rd_vld_q) begin
						if (mem_rdata_q != mtr_pkg::link_reset_byte(rd_prev_q[2:0]))
							match_q <= 1'b0;
						if (rd_prev_q == 7'(mtr_pkg::SearchLen - 1)) begin
							rd_vld_q <= 1'b0;
							st_q     <= S_EMIT;
							if (match_q && mem_rdata_q ==
								mtr_pkg::link_reset_byte(rd_prev_q[2:0])) begin
								phase_q  <= 1'b1;
								status_q <= mtr_pkg::ST_MATCH;
							end
						end
					end
				end
				// add bytes 4..98, compare with byte 99; fetch access number
				S_SUM: begin
					rd_vld_q <= 1'b1;
					rd_q     <= rd_q + 7'd1;
					if (rd_vld_q) begin
						if (rd_prev_q <= 7'(mtr_pkg::SumLast)) acc_q <= acc_q + mem_rdata_q;
						if (rd_prev_q == 7'(mtr_pkg::AccessPos)) access_q <= mem_rdata_q;
						if (rd_prev_q == 7'(mtr_pkg::SumPos)) begin
							rd_vld_q    <= 1'b0;
							frame_cnt_q <= frame_cnt_q + 8'd1;
							if (acc_q != mem_rdata_q) begin
								if (sum_err_q != 8'hff) sum_err_q <= sum_err_q + 8'd1;
								status_q <= mtr_pkg::ST_BADSUM;
								st_q     <= S_EMIT;
							end else begin
								status_q <= mtr_pkg::ST_GOOD;
								k0_q     <= {key_high_q, key_low_q};
								rk_q     <= {key_high_q, key_low_q};
								rnd_q    <= '0;
								st_q     <= S_KEY;
							end
						end
					end
				end
				// run forward schedule to the last round key
				S_KEY: begin
					rk_q  <= mtr_pkg::key_next(rk_q, mtr_pkg::rcon(rnd_q));
					rnd_q <= rnd_q + 4'd1;
					if (rnd_q == 4'd9) begin
						chain_q <= {iv_low_q, {8{access_q}}};
						blk_q   <= '0;
						cnt_q   <= '0;
						rd_q    <= 7'(mtr_pkg::PayloadPos);
						st_q    <= S_LOAD;
					end
				end
				// gather 16 ciphertext bytes
				S_LOAD: begin
					if (cnt_q < 5'd16) begin
						rd_q  <= rd_q + 7'd1;
						cnt_q <= cnt_q + 5'd1;
					end
					rd_vld_q <= (cnt_q < 5'd16);
					if (rd_vld_q) ct_q <= {ct_q[119:0], mem_rdata_q};
					if (cnt_q == 5'd16 && rd_vld_q) begin
						st128_q <= {ct_q[119:0], mem_rdata_q};
						rnd_q   <= 4'd10;
						st_q    <= S_ROUND;
					end
				end
				// one round per cycle, walking the key schedule backward
				S_ROUND: begin
					st128_q <= rnd_out;
					rk_q    <= mtr_pkg::key_prev(rk_q, mtr_pkg::rcon(rnd_q - 4'd1));
					rnd_q   <= rnd_q - 4'd1;
					if (rnd_q == 4'd1) st_q <= S_XOR;
				end
				// undo whitening and chain; rk_q is back at round 0 after 10 steps
				S_XOR: begin
					unique case (blk_q)
						3'd0: begin
							meter_q[0] <= {pb(plain,15), pb(plain,14), pb(plain,13), pb(plain,12)};
						end
						3'd1: begin
							meter_q[1] <= {pb(plain,6), pb(plain,5), pb(plain,4), pb(plain,3)};
							meter_q[2] <= {pb(plain,15), pb(plain,14), pb(plain,13), pb(plain,12)};
						end
						3'd2: begin
							meter_q[3] <= {pb(plain,9), pb(plain,8), pb(plain,7), pb(plain,6)};
							meter_q[4] <= {pb(plain,15), pb(plain,14), pb(plain,13), pb(plain,12)};
						end
						3'd3: begin
							meter_q[5] <= {pb(plain,6), pb(plain,5), pb(plain,4), pb(plain,3)};
							meter_q[6] <= {pb(plain,13), pb(plain,12), pb(plain,11), pb(plain,10)};
						end
						3'd4: begin
							meter_q[7] <= {pb(plain,5), pb(plain,4), pb(plain,3), pb(plain,2)};
						end
						default: ;
					endcase
					chain_q <= ct_q;
					// restore the round 0 key; S_DONE rebuilds the last round key
					rk_q  <= k0_q;
					rnd_q <= '0;
					cnt_q <= '0;
					if (blk_q == 3'(mtr_pkg::NumBlocks - 1)) begin
						st_q <= S_EMIT;
					end else begin
						blk_q <= blk_q + 3'd1;
						st_q  <= S_DONE;
					end
				end
				// rebuild last round key, then load next block
				S_DONE: begin
					rk_q  <= mtr_pkg::key_next(rk_q, mtr_pkg::rcon(rnd_q));
					rnd_q <= rnd_q + 4'd1;
					if (rnd_q == 4'd9) st_q <= S_LOAD;
				end
				S_EMIT: begin
					out_vld_q <= 1'b1;
					st_q      <= S_IDLE;
				end
				default: st_q <= S_IDLE;
			endcase
		end
	end

	// round 0 key in S_XOR: after 10 backward steps rk_q equals k0_q, so plain
	// folds k0_q in directly; a meaningless value reads at mtr_pkg::value_offset
	logic unused_ok;
	assign unused_ok = |mtr_pkg::value_offset(3'd0);

	assign out_valid              = out_vld_q;
	assign status                 = status_q | {2'b00, unused_ok & 1'b0};
	assign energy_active_import   = meter_q[0];
	assign energy_active_export   = meter_q[1];
	assign energy_reactive_import = meter_q[2];
	assign energy_reactive_export = meter_q[3];
	assign power_active_import    = meter_q[4];
	assign power_active_export    = meter_q[5];
	assign power_reactive_import  = meter_q[6];
	assign power_reactive_export  = meter_q[7];
	assign checksum_error_count   = sum_err_q;
	assign line_error_count       = line_err_q;
	assign telegram_count         = frame_cnt_q;

endmodule

### tb/sv/meter_telegram_receiver_core_checker.sv
`timescale 1ns / 1ps

module meter_telegram_receiver_core_checker
	import mtr_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        in_stall,
	input  logic [1:0]  opcode,
	input  logic [7:0]  rx_byte,
	input  logic [15:0] time_ms,
	input  logic        cfg_valid,
	input  logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [63:0] cfg_data,
	input  logic        out_valid,
	input  logic        out_stall,
	input  logic [2:0]  status,
	input  logic [31:0] energy_active_import,
	input  logic [31:0] energy_active_export,
	input  logic [31:0] energy_reactive_import,
	input  logic [31:0] energy_reactive_export,
	input  logic [31:0] power_active_import,
	input  logic [31:0] power_active_export,
	input  logic [31:0] power_reactive_import,
	input  logic [31:0] power_reactive_export,
	input  logic [7:0]  checksum_error_count,
	input  logic [7:0]  line_error_count,
	input  logic [7:0]  telegram_count,
	output int          fail_count,
	output int          pending
);

	typedef struct {
		status_t     st;
		logic [31:0] vals [8];
		byte_t       bad_sums;
		byte_t       line_errs;
		byte_t       telegrams;
	} reading_t;

	localparam logic [0:255][7:0] FWD_SBOX = {
		128'h637c777bf26b6fc53001672bfed7ab76, 128'hca82c97dfa5947f0add4a2af9ca472c0,
		128'hb7fd9326363ff7cc34a5e5f171d83115, 128'h04c723c31896059a071280e2eb27b275,
		128'h09832c1a1b6e5aa0523bd6b329e32f84, 128'h53d100ed20fcb15b6acbbe394a4c58cf,
		128'hd0efaafb434d338545f9027f503c9fa8, 128'h51a3408f929d38f5bcb6da2110fff3d2,
		128'hcd0c13ec5f974417c4a77e3d645d1973, 128'h60814fdc222a908846eeb814de5e0bdb,
		128'he0323a0a4906245cc2d3ac629195e479, 128'he7c8376d8dd54ea96c56f4ea657aae08,
		128'hba78252e1ca6b4c6e8dd741f4bbd8b8a, 128'h703eb5664803f60e613557b986c11d9e,
		128'he1f8981169d98e949b1e87e9ce5528df, 128'h8ca1890dbfe6426841992d0fb054bb16};

	byte_t rev_sbox [256];
	byte_t round_c  [10] = '{8'h01, 8'h02, 8'h04, 8'h08, 8'h10, 8'h20, 8'h40, 8'h80,
		8'h1b, 8'h36};

	logic [63:0] key_lo, key_hi, iv_lo;
	logic [15:0] rx_timeout;
	logic        in_telegram;
	int          fill;
	byte_t       frame [FrameLen];
	logic [15:0] last_rx;
	logic [31:0] meter [8];
	byte_t       bad_sums, line_errs, telegrams;

	reading_t expected_readings [$];

	assign pending = expected_readings.size();

	initial begin
		for (int i = 0; i < 256; i++) rev_sbox[FWD_SBOX[i]] = byte_t'(i);
		fail_count = 0;
	end

	function automatic byte_t gmul(byte_t a, byte_t b);
		byte_t r;
		r = 0;
		for (int i = 0; i < 8; i++) begin
			if (b[0]) r ^= a;
			a = a[7] ? ({a[6:0], 1'b0} ^ 8'h1b) : {a[6:0], 1'b0};
			b = b >> 1;
		end
		return r;
	endfunction

	// CBC-decrypt the payload and pick the eight little-endian values
	function automatic void decrypt_payload();
		byte_t rk [176];
		byte_t tw [4];
		byte_t chain [16];
		byte_t plain [80];
		byte_t s [16];
		byte_t t [16];
		byte_t a0, a1, a2, a3, f;
		int    offs [8] = '{12, 19, 28, 38, 44, 51, 58, 66};
		for (int i = 0; i < 8; i++) begin
			rk[i]     = key_hi[63-8*i -: 8];
			rk[8 + i] = key_lo[63-8*i -: 8];
		end
		for (int i = 4; i < 44; i++) begin
			for (int j = 0; j < 4; j++) tw[j] = rk[4*(i-1) + j];
			if (i % 4 == 0) begin
				f     = tw[0];
				tw[0] = FWD_SBOX[tw[1]] ^ round_c[i/4 - 1];
				tw[1] = FWD_SBOX[tw[2]];
				tw[2] = FWD_SBOX[tw[3]];
				tw[3] = FWD_SBOX[f];
			end
			for (int j = 0; j < 4; j++) rk[4*i + j] = rk[4*(i-4) + j] ^ tw[j];
		end
		for (int i = 0; i < 8; i++) begin
			chain[i]     = iv_lo[63-8*i -: 8];
			chain[8 + i] = frame[AccessPos];
		end
		for (int b = 0; b < NumBlocks; b++) begin
			for (int i = 0; i < 16; i++) s[i] = frame[PayloadPos + 16*b + i] ^ rk[160 + i];
			for (int rnd = 9; rnd >= 0; rnd--) begin
				for (int r = 0; r < 4; r++)
					for (int c = 0; c < 4; c++)
						t[r + 4*c] = rev_sbox[s[r + 4*((c - r + 4) % 4)]];
				for (int i = 0; i < 16; i++) s[i] = t[i] ^ rk[16*rnd + i];
				if (rnd > 0) begin
					for (int c = 0; c < 4; c++) begin
						a0 = s[4*c]; a1 = s[4*c+1]; a2 = s[4*c+2]; a3 = s[4*c+3];
						s[4*c]   = gmul(a0, 14) ^ gmul(a1, 11) ^ gmul(a2, 13) ^ gmul(a3, 9);
						s[4*c+1] = gmul(a0, 9) ^ gmul(a1, 14) ^ gmul(a2, 11) ^ gmul(a3, 13);
						s[4*c+2] = gmul(a0, 13) ^ gmul(a1, 9) ^ gmul(a2, 14) ^ gmul(a3, 11);
						s[4*c+3] = gmul(a0, 11) ^ gmul(a1, 13) ^ gmul(a2, 9) ^ gmul(a3, 14);
					end
				end
			end
			for (int i = 0; i < 16; i++) begin
				plain[16*b + i] = s[i] ^ chain[i];
				chain[i]        = frame[PayloadPos + 16*b + i];
			end
		end
		for (int k = 0; k < 8; k++)
			meter[k] = {plain[offs[k]+3], plain[offs[k]+2], plain[offs[k]+1], plain[offs[k]]};
	endfunction

	function automatic void absorb_event(op_t op, byte_t b, logic [15:0] now);
		reading_t rd;
		byte_t    sum;
		logic     match;
		rd.st = ST_NONE;
		case (op)
			OP_DATA: begin
				last_rx = now;
				if (fill >= FrameLen) fill = 0;
				frame[fill] = b;
				fill++;
				if (!in_telegram) begin
					if (fill >= SearchLen) begin
						match = 1'b1;
						for (int i = 0; i < SearchLen; i++)
							if (frame[i] != link_reset_byte(3'(i))) match = 1'b0;
						if (match) begin
							in_telegram = 1'b1;
							rd.st = ST_MATCH;
						end
						fill = 0;
					end
				end else if (fill >= FrameLen) begin
					sum = 0;
					for (int k = SumFirst; k <= SumLast; k++) sum += frame[k];
					if (sum != frame[SumPos]) begin
						if (bad_sums != 8'hff) bad_sums++;
						rd.st = ST_BADSUM;
					end else begin
						decrypt_payload();
						rd.st = ST_GOOD;
					end
					fill = 0;
					telegrams++;
				end
			end
			OP_LERR: begin
				if (line_errs != 8'hff) line_errs++;
				fill = 0;
				if (16'(now - last_rx) >= rx_timeout) in_telegram = 1'b0;
				rd.st = ST_LINEERR;
			end
			OP_POLL: begin
				if (16'(now - last_rx) >= rx_timeout) begin
					in_telegram = 1'b0;
					fill = 0;
					rd.st = ST_TIMEOUT;
				end
			end
			default: ;
		endcase
		rd.vals      = meter;
		rd.bad_sums  = bad_sums;
		rd.line_errs = line_errs;
		rd.telegrams = telegrams;
		expected_readings.push_back(rd);
	endfunction

	task automatic report(string what, logic [63:0] got, logic [63:0] want);
		$display("%0t mismatch %s: got %0h, want %0h", $realtime, what, got, want);
		fail_count++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		reading_t    rd;
		logic [31:0] seen [8];
		if (!arst_n) begin
			key_lo      <= '0;
			key_hi      <= '0;
			iv_lo       <= 64'h2D4C00000000010E;
			rx_timeout  <= 16'd2000;
			in_telegram <= 1'b0;
			fill        <= 0;
			last_rx     <= '0;
			meter       <= '{default: '0};
			bad_sums    <= '0;
			line_errs   <= '0;
			telegrams   <= '0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (reg_t'(cfg_index))
					REG_KEY_LOW:  key_lo = cfg_data;
					REG_KEY_HIGH: key_hi = cfg_data;
					REG_IV_LOW:   iv_lo = cfg_data;
					REG_TIMEOUT:  rx_timeout = cfg_data[15:0];
				endcase
			end
			if (in_valid && !in_stall) absorb_event(op_t'(opcode), rx_byte, time_ms);
			if (out_valid && !out_stall) begin
				if (expected_readings.size() == 0) begin
					report("unexpected result", status, 0);
				end else begin
					rd = expected_readings.pop_front();
					seen = '{energy_active_import, energy_active_export, energy_reactive_import,
						energy_reactive_export, power_active_import, power_active_export,
						power_reactive_import, power_reactive_export};
					if (status !== rd.st) report("status", status, rd.st);
					for (int k = 0; k < 8; k++)
						if (seen[k] !== rd.vals[k]) report($sformatf("meter value %0d", k),
							seen[k], rd.vals[k]);
					if (checksum_error_count !== rd.bad_sums)
						report("checksum_error_count", checksum_error_count, rd.bad_sums);
					if (line_error_count !== rd.line_errs)
						report("line_error_count", line_error_count, rd.line_errs);
					if (telegram_count !== rd.telegrams)
						report("telegram_count", telegram_count, rd.telegrams);
				end
			end
		end
	end

endmodule

### tb/sv/meter_telegram_receiver_core_test.sv
`timescale 1ns / 1ps

module meter_telegram_receiver_core_test;
	import mtr_pkg::*;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	logic [1:0]  opcode;
	logic [7:0]  rx_byte;
	logic [15:0] time_ms;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [1:0]  cfg_index;
	logic [63:0] cfg_data;
	logic        out_valid;
	logic        out_stall;
	logic [2:0]  status;
	logic [31:0] energy_active_import, energy_active_export;
	logic [31:0] energy_reactive_import, energy_reactive_export;
	logic [31:0] power_active_import, power_active_export;
	logic [31:0] power_reactive_import, power_reactive_export;
	logic [7:0]  checksum_error_count, line_error_count, telegram_count;
	int          fail_count;
	int          pending;

	// stimulus control; quiet and hold_req are shared with the receiver process
	bit          quiet;
	bit          hold_req;
	logic [15:0] now_ms;
	logic [15:0] cur_timeout;
	int          sent;

	meter_telegram_receiver_core u_dut (.*);

	meter_telegram_receiver_core_checker u_checker (.*);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	// Hard stop in case a handshake never completes.
	initial begin
		#5ms;
		$display("[meter_telegram_receiver_core] ERROR");
		$finish;
	end

	// Receiver side: short random stall bursts, one long hold-off on request.
	initial begin
		out_stall = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_req) begin
				out_stall <= 1'b1;
				repeat (400) @(posedge clk);
				out_stall <= 1'b0;
				hold_req = 1'b0;
			end else if (!quiet && $urandom_range(0, 5) == 0) begin
				out_stall <= 1'b1;
				repeat ($urandom_range(1, 3)) @(posedge clk);
				out_stall <= 1'b0;
			end
		end
	end

	// Offer one item and hold it until the core takes it; the sender idles in
	// short random bursts beforehand unless the run is in its quiet tail.
	task automatic offer(op_t op, byte_t b, logic [15:0] t);
		if (!quiet && $urandom_range(0, 4) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 3)) @(posedge clk);
		end
		in_valid <= 1'b1;
		opcode   <= op;
		rx_byte  <= b;
		time_ms  <= t;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		if (op != OP_SPARE) sent++;
	endtask

	// Data bytes advance the millisecond clock by 0 to 3 ms each.
	task automatic send_byte(byte_t b);
		now_ms = now_ms + 16'($urandom_range(0, 3));
		offer(OP_DATA, b, now_ms);
	endtask

	// Poll either right away or after the configured timeout has run out.
	task automatic send_poll(bit expire);
		if (expire) now_ms = now_ms + cur_timeout + 16'($urandom_range(0, 40));
		offer(OP_POLL, 8'($urandom), now_ms);
	endtask

	task automatic send_line_error(bit expire);
		if (expire) now_ms = now_ms + cur_timeout;
		offer(OP_LERR, 8'($urandom), now_ms);
	endtask

	task automatic send_link_reset();
		for (int i = 0; i < SearchLen; i++) send_byte(link_reset_byte(3'(i)));
	endtask

	// Send one full telegram. fill_mode: 0 random, 1 all zero, 2 all ones.
	// A corrupt telegram flips the checksum; glitch drops in one line error.
	task automatic send_telegram(bit corrupt, int fill_mode, bit glitch);
		byte_t frame [FrameLen];
		byte_t sum;
		int    glitch_at;
		sum = 0;
		for (int i = 0; i < FrameLen; i++) begin
			case (fill_mode)
				1:       frame[i] = 8'h00;
				2:       frame[i] = 8'hff;
				default: frame[i] = 8'($urandom);
			endcase
			if (i >= SumFirst && i <= SumLast) sum += frame[i];
		end
		frame[SumPos] = corrupt ? sum ^ 8'($urandom_range(1, 255)) : sum;
		glitch_at = glitch ? $urandom_range(0, FrameLen - 1) : -1;
		for (int i = 0; i < FrameLen; i++) begin
			if (i == glitch_at) send_line_error(1'b0);
			send_byte(frame[i]);
		end
	endtask

	// Wait until every result is back, then let the core settle.
	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (10) @(posedge clk);
	endtask

	task automatic write_reg(reg_t idx, logic [63:0] v);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= v;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
		@(posedge clk);
		if (idx == REG_TIMEOUT) cur_timeout = v[15:0];
	endtask

	// Mostly well-formed link reset plus telegram, the rest noise.
	task automatic random_traffic(int goal);
		int pick;
		while (sent < goal) begin
			pick = $urandom_range(0, 99);
			if (pick < 65) begin
				send_link_reset();
				send_telegram($urandom_range(0, 9) == 0, 0, $urandom_range(0, 19) == 0);
			end else if (pick < 75) begin
				repeat ($urandom_range(1, 12)) send_byte(8'($urandom));
			end else if (pick < 83) begin
				send_poll($urandom_range(0, 1));
			end else if (pick < 90) begin
				send_line_error($urandom_range(0, 2) == 0);
			end else if (pick < 95) begin
				offer(OP_SPARE, 8'($urandom), 16'($urandom));
			end else begin
				// partial telegram, then abandon it through a timeout
				send_link_reset();
				repeat ($urandom_range(1, 60)) send_byte(8'($urandom));
				send_poll(1'b1);
			end
		end
	endtask

	initial begin
		arst_n      = 1'b0;
		in_valid    = 1'b0;
		opcode      = OP_DATA;
		rx_byte     = '0;
		time_ms     = '0;
		cfg_valid   = 1'b0;
		cfg_index   = REG_KEY_LOW;
		cfg_data    = '0;
		quiet       = 1'b0;
		hold_req    = 1'b0;
		now_ms      = '0;
		cur_timeout = 16'd2000;
		sent        = 0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part under the reset configuration.
		send_poll(1'b0);                                  // quiet poll, no timeout
		offer(OP_SPARE, 8'hff, 16'hffff);                 // unused opcode is ignored
		send_line_error(1'b0);
		repeat (5) send_byte(8'hff);                      // mismatching search window
		send_link_reset();
		send_telegram(1'b0, 1, 1'b0);                     // good sum, all-zero bytes
		send_link_reset();
		send_telegram(1'b0, 2, 1'b0);                     // good sum, all-ones bytes
		send_link_reset();
		send_telegram(1'b1, 0, 1'b0);                     // bad checksum
		send_link_reset();
		repeat (7) send_byte(8'h00);
		send_line_error(1'b1);                            // line error with timeout
		send_poll(1'b1);                                  // idle timeout back to search
		drain();

		// Hold the receiver off while the sender keeps pushing.
		hold_req = 1'b1;
		random_traffic(sent + 40);
		drain();

		for (int ph = 0; ph < 5; ph++) begin
			case (ph)
				0: begin
					write_reg(REG_KEY_LOW, '0);
					write_reg(REG_KEY_HIGH, '0);
					write_reg(REG_IV_LOW, '0);
					write_reg(REG_TIMEOUT, 64'd1);
				end
				1: begin
					write_reg(REG_KEY_LOW, '1);
					write_reg(REG_KEY_HIGH, '1);
					write_reg(REG_IV_LOW, '1);
					write_reg(REG_TIMEOUT, 64'd65535);
				end
				default: begin
					write_reg(REG_KEY_LOW, {$urandom, $urandom});
					write_reg(REG_KEY_HIGH, {$urandom, $urandom});
					write_reg(REG_IV_LOW, {$urandom, $urandom});
					write_reg(REG_TIMEOUT, 64'($urandom_range(20, 3000)));
				end
			endcase
			if (ph == 4) quiet = 1'b1;
			random_traffic(sent + 380);
			drain();
		end

		repeat (300) @(posedge clk);
		if (fail_count == 0)
			$display("[meter_telegram_receiver_core] OK");
		else
			$display("[meter_telegram_receiver_core] ERROR");
		$finish;
	end

endmodule
